[rtl/core/ctd_pkg.sv]
`timescale 1ns / 1ps

package ctd_pkg;

   // number of tunable parameters
   localparam int unsigned N_TUNED = 3;

   // field widths
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned VAL_W   = 32;
   localparam int unsigned DECAY_W = 16;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 1;

   // parameter memory addressing
   localparam int unsigned ADDR_W = (N_TUNED > 1) ? $clog2(N_TUNED) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(N_TUNED - 1);
   localparam logic [IDX_W:0]    PARAM_COUNT = (IDX_W + 1)'(N_TUNED);

   // register defaults
   localparam logic [DECAY_W-1:0] DECAY_RESET    = 16'd52429;
   localparam logic [VAL_W-1:0]   MIN_STEP_RESET = 32'd66;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_STEP = 1'b1;

   // request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_SCORE = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic [IDX_W-1:0]        entry_index;
      logic signed [VAL_W-1:0] start_value;
      logic [VAL_W-1:0]        base_step;
      logic signed [VAL_W-1:0] score;
   } ctd_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        out_index;
      logic signed [VAL_W-1:0] out_value;
      logic signed [VAL_W-1:0] best_score;
      logic                    last;
   } ctd_rsp_type;

   // one parameter entry as held in memory
   typedef struct packed {
      logic signed [VAL_W-1:0] trial;
      logic signed [VAL_W-1:0] best;
      logic signed [VAL_W-1:0] base;
      logic [VAL_W-1:0]        step;
      logic [VAL_W-1:0]        init;
   } ctd_entry_type;

   // direction / index updates from the step unit
   typedef struct packed {
      logic flip;
      logic advance;
   } ctd_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_EMIT
   } ctd_state_type;

endpackage

[rtl/core/ctd_param_ram.sv]
`timescale 1ns / 1ps

// Parameter entry store: one write port, one read port, registered read data.
module ctd_param_ram (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ctd_pkg::ADDR_W-1:0]    wr_addr,
   input  ctd_pkg::ctd_entry_type        wr_data,
   input  logic                          rd_en,
   input  logic [ctd_pkg::ADDR_W-1:0]    rd_addr,
   output ctd_pkg::ctd_entry_type        rd_data
);

   ctd_pkg::ctd_entry_type mem [ctd_pkg::N_TUNED];
   ctd_pkg::ctd_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ctd_step_unit.sv]
`timescale 1ns / 1ps

// Twiddle step rule for the active entry.
// With prod_en high, step * decay is registered; the decision and the new entry use that registered product.
module ctd_step_unit (
   input  logic                              clock,
   input  logic                              prod_en,
   input  ctd_pkg::ctd_entry_type            cur,
   input  logic                              going_up,
   input  logic                              improve,
   input  logic [ctd_pkg::DECAY_W-1:0]       decay,
   input  logic [ctd_pkg::VAL_W-1:0]         min_step,
   output ctd_pkg::ctd_entry_type            nxt,
   output ctd_pkg::ctd_flags_type            flags
);

   localparam int unsigned PROD_W = ctd_pkg::VAL_W + ctd_pkg::DECAY_W;

   logic [ctd_pkg::VAL_W-1:0]        shrunk_ff;
   logic [ctd_pkg::VAL_W-1:0]        shrunk_in;
   logic [PROD_W-1:0]                prod;
   logic                             below_min;
   logic signed [ctd_pkg::VAL_W-1:0] add_val;
   logic [ctd_pkg::VAL_W-1:0]        add_step;
   logic                             add_up;
   logic signed [ctd_pkg::VAL_W+1:0] sum;
   logic signed [ctd_pkg::VAL_W-1:0] moved;
   logic signed [ctd_pkg::VAL_W-1:0] moved_clamped;

   // shrunk step, truncated Q16.16
   assign prod      = PROD_W'(cur.step) * PROD_W'(decay);
   assign shrunk_in = prod[PROD_W-1:ctd_pkg::DECAY_W];

   always_ff @(posedge clock) begin
      if (prod_en) begin
         shrunk_ff <= shrunk_in;
      end
   end

   assign below_min = (shrunk_ff < min_step);

   // shared saturating adder operands
   always_comb begin
      if (improve) begin
         add_val  = cur.trial;
         add_step = cur.step;
         add_up   = going_up;
      end else if (below_min) begin
         add_val  = cur.base;
         add_step = cur.init;
         add_up   = 1'b0;
      end else begin
         add_val  = cur.base;
         add_step = shrunk_ff;
         add_up   = going_up;
      end
   end

   // two guard bits: value plus a full 32-bit step can reach nearly 3 * 2^31 in magnitude
   assign sum = add_up ? ({{2{add_val[ctd_pkg::VAL_W-1]}}, add_val} + {2'b00, add_step})
                       : ({{2{add_val[ctd_pkg::VAL_W-1]}}, add_val} - {2'b00, add_step});

   always_comb begin
      if ((sum[ctd_pkg::VAL_W+1] != sum[ctd_pkg::VAL_W]) ||
          (sum[ctd_pkg::VAL_W] != sum[ctd_pkg::VAL_W-1])) begin
         moved = sum[ctd_pkg::VAL_W+1] ? {1'b1, {(ctd_pkg::VAL_W-1){1'b0}}}
                                       : {1'b0, {(ctd_pkg::VAL_W-1){1'b1}}};
      end else begin
         moved = sum[ctd_pkg::VAL_W-1:0];
      end
   end

   assign moved_clamped = moved[ctd_pkg::VAL_W-1] ? '0 : moved;

   // new entry and control flags
   always_comb begin
      nxt   = cur;
      flags = '0;
      if (improve) begin
         nxt.best  = cur.trial;
         nxt.base  = cur.trial;
         nxt.trial = moved;
      end else if (!below_min) begin
         nxt.step  = shrunk_ff;
         nxt.trial = moved_clamped;
      end else if (going_up) begin
         nxt.step   = cur.init;
         nxt.trial  = moved_clamped;
         flags.flip = 1'b1;
      end else begin
         nxt.step      = cur.init;
         nxt.trial     = cur.best;
         flags.advance = 1'b1;
      end
   end

endmodule

[rtl/core/coordinate_descent_tuner_top.sv]
`timescale 1ns / 1ps

// Load beat: an index below N_TUNED is written to the memory at the accepting edge; busy stays low.
// Score beat: busy in FETCH (read data of the active entry, step multiply), UPDATE (update and
// write back) and EMIT over all N_TUNED entries; the first score skips straight to emission.
// Results are the registered EMIT reads, one per cycle; the next beat is taken once the tuner
// is back in IDLE. No receiver stall.
// Reset (synchronous, active high) restores the registers and tuner state; entries are not cleared.
module coordinate_descent_tuner_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  ctd_pkg::ctd_req_type              req_payload,
   output logic                              rsp_strobe,
   output ctd_pkg::ctd_rsp_type              rsp_payload,
   input  logic                              csr_we,
   input  logic [ctd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ctd_pkg::CSR_W-1:0]         csr_wdata
);

   ctd_pkg::ctd_state_type           state_ff, state_in;
   logic [ctd_pkg::DECAY_W-1:0]      decay_ff;
   logic [ctd_pkg::VAL_W-1:0]        min_step_ff;
   logic [ctd_pkg::ADDR_W-1:0]       active_ff, active_in;
   logic                             going_up_ff, going_up_in;
   logic signed [ctd_pkg::VAL_W-1:0] best_seen_ff, best_seen_in;
   logic                             have_best_ff, have_best_in;
   logic signed [ctd_pkg::VAL_W-1:0] score_ff;
   logic [ctd_pkg::ADDR_W-1:0]       cnt_ff, cnt_in;
   logic                             rsp_valid_ff;
   logic [ctd_pkg::ADDR_W-1:0]       rsp_idx_ff;
   logic                             rsp_last_ff;

   logic                             accept;
   logic                             load_ok;
   logic                             improve;
   logic                             mem_we;
   logic [ctd_pkg::ADDR_W-1:0]       mem_waddr;
   ctd_pkg::ctd_entry_type           mem_wdata;
   logic                             mem_re;
   logic [ctd_pkg::ADDR_W-1:0]       mem_raddr;
   ctd_pkg::ctd_entry_type           mem_rdata;
   ctd_pkg::ctd_entry_type           load_entry;
   ctd_pkg::ctd_entry_type           upd_entry;
   ctd_pkg::ctd_flags_type           upd_flags;
   logic                             prod_en;
   logic                             emit_go;

   assign accept  = start && !busy;
   assign load_ok = ({1'b0, req_payload.entry_index} < ctd_pkg::PARAM_COUNT);
   assign improve = (score_ff > best_seen_ff);

   // load beat entry
   always_comb begin
      load_entry.trial = req_payload.start_value;
      load_entry.best  = req_payload.start_value;
      load_entry.base  = req_payload.start_value;
      load_entry.step  = req_payload.base_step;
      load_entry.init  = req_payload.base_step;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff    <= ctd_pkg::DECAY_RESET;
         min_step_ff <= ctd_pkg::MIN_STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ctd_pkg::CSR_DECAY:    decay_ff    <= csr_wdata[ctd_pkg::DECAY_W-1:0];
            ctd_pkg::CSR_MIN_STEP: min_step_ff <= csr_wdata[ctd_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ctd_pkg::ST_IDLE: begin
            if (accept && req_payload.req_type == ctd_pkg::REQ_SCORE) begin
               state_in = have_best_ff ? ctd_pkg::ST_FETCH : ctd_pkg::ST_EMIT;
            end
         end
         ctd_pkg::ST_FETCH:  state_in = ctd_pkg::ST_UPDATE;
         ctd_pkg::ST_UPDATE: state_in = ctd_pkg::ST_EMIT;
         ctd_pkg::ST_EMIT: begin
            if (cnt_ff == ctd_pkg::LAST_ADDR) begin
               state_in = ctd_pkg::ST_IDLE;
            end
         end
         default: state_in = ctd_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy      = 1'b1;
      mem_we    = 1'b0;
      mem_waddr = active_ff;
      mem_wdata = upd_entry;
      mem_re    = 1'b0;
      mem_raddr = active_ff;
      prod_en   = 1'b0;
      emit_go   = 1'b0;
      case (state_ff)
         ctd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept && req_payload.req_type == ctd_pkg::REQ_LOAD && load_ok) begin
               mem_we    = 1'b1;
               mem_waddr = req_payload.entry_index[ctd_pkg::ADDR_W-1:0];
               mem_wdata = load_entry;
            end
            if (accept && req_payload.req_type == ctd_pkg::REQ_SCORE && have_best_ff) begin
               mem_re = 1'b1;
            end
         end
         ctd_pkg::ST_FETCH: begin
            prod_en = 1'b1;
         end
         ctd_pkg::ST_UPDATE: begin
            mem_we = 1'b1;
         end
         ctd_pkg::ST_EMIT: begin
            mem_re    = 1'b1;
            mem_raddr = cnt_ff;
            emit_go   = 1'b1;
         end
         default: ;
      endcase
   end

   // tuner score state
   always_comb begin
      active_in    = active_ff;
      going_up_in  = going_up_ff;
      best_seen_in = best_seen_ff;
      have_best_in = have_best_ff;
      if (accept && req_payload.req_type == ctd_pkg::REQ_SCORE && !have_best_ff) begin
         have_best_in = 1'b1;
         best_seen_in = req_payload.score;
      end
      if (state_ff == ctd_pkg::ST_UPDATE) begin
         if (improve) begin
            best_seen_in = score_ff;
         end
         if (upd_flags.flip) begin
            going_up_in = 1'b0;
         end
         if (upd_flags.advance) begin
            going_up_in = 1'b1;
            active_in   = (active_ff == ctd_pkg::LAST_ADDR) ? '0 : active_ff + 1'b1;
         end
      end
   end

   assign cnt_in = (emit_go && cnt_ff != ctd_pkg::LAST_ADDR) ? cnt_ff + 1'b1 : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctd_pkg::ST_IDLE;
         active_ff    <= '0;
         going_up_ff  <= 1'b1;
         best_seen_ff <= '0;
         have_best_ff <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         going_up_ff  <= going_up_in;
         best_seen_ff <= best_seen_in;
         have_best_ff <= have_best_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= emit_go;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         score_ff <= req_payload.score;
      end
      rsp_idx_ff  <= cnt_ff;
      rsp_last_ff <= (cnt_ff == ctd_pkg::LAST_ADDR);
   end

   ctd_param_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ctd_step_unit u_step (
      .clock    (clock),
      .prod_en  (prod_en),
      .cur      (mem_rdata),
      .going_up (going_up_ff),
      .improve  (improve),
      .decay    (decay_ff),
      .min_step (min_step_ff),
      .nxt      (upd_entry),
      .flags    (upd_flags)
   );

   // result beat: read data of the emission sweep
   assign rsp_strobe             = rsp_valid_ff;
   assign rsp_payload.out_index  = ctd_pkg::IDX_W'(rsp_idx_ff);
   assign rsp_payload.out_value  = mem_rdata.trial;
   assign rsp_payload.best_score = best_seen_ff;
   assign rsp_payload.last       = rsp_last_ff;

endmodule

[tb/tb_coordinate_descent_tuner_top.sv]
`timescale 1ns / 1ps

module tb_coordinate_descent_tuner_top;

   localparam int LIMIT_CYCLES = 200000;
   localparam int TAIL_CYCLES  = ctd_pkg::N_TUNED + 8;
   localparam int PHASES       = 6;
   localparam int PHASE_BEATS  = 52;

   // register settings and sender idle rate per random phase
   localparam logic [ctd_pkg::DECAY_W-1:0] PHASE_DECAY [PHASES] =
      '{16'hCCCD, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'hC000};
   localparam logic [ctd_pkg::CSR_W-1:0] PHASE_MIN_STEP [PHASES] =
      '{32'd66, 32'h0000_1000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0100};
   localparam int PHASE_IDLE [PHASES] = '{0, 77, 14, 0, 77, 14};

   // twiddle tuner mirror: entry table, search state, expected parameter beats
   class tuner_scoreboard;
      logic [ctd_pkg::DECAY_W-1:0]      decay;
      logic [ctd_pkg::VAL_W-1:0]        min_step;
      logic signed [ctd_pkg::VAL_W-1:0] trial    [ctd_pkg::N_TUNED];
      logic signed [ctd_pkg::VAL_W-1:0] best_val [ctd_pkg::N_TUNED];
      logic signed [ctd_pkg::VAL_W-1:0] base_val [ctd_pkg::N_TUNED];
      logic [ctd_pkg::VAL_W-1:0]        step     [ctd_pkg::N_TUNED];
      logic [ctd_pkg::VAL_W-1:0]        init_step[ctd_pkg::N_TUNED];
      int unsigned                      active;
      bit                               going_up;
      logic signed [ctd_pkg::VAL_W-1:0] best_score;
      bit                               have_best;
      ctd_pkg::ctd_rsp_type             pending_params[$];
      int unsigned                      errors;
      int unsigned                      results_seen;
      int unsigned                      scores_seen;
      int unsigned                      beats_seen;

      function new();
         decay      = ctd_pkg::DECAY_RESET;
         min_step   = ctd_pkg::MIN_STEP_RESET;
         active     = 0;
         going_up   = 1'b1;
         best_score = '0;
         have_best  = 1'b0;
         errors     = 0;
         results_seen = 0;
         scores_seen  = 0;
         beats_seen   = 0;
      endfunction

      function void write_reg(logic [ctd_pkg::CSR_IDX_W-1:0] idx,
                              logic [ctd_pkg::CSR_W-1:0] data);
         if (idx == ctd_pkg::CSR_DECAY)
            decay = data[ctd_pkg::DECAY_W-1:0];
         else
            min_step = data;
      endfunction

      // value +/- step, saturated to the signed 32-bit range
      static function logic signed [ctd_pkg::VAL_W-1:0] nudge(
            logic signed [ctd_pkg::VAL_W-1:0] v, logic [ctd_pkg::VAL_W-1:0] s, bit up);
         longint sum;
         sum = up ? longint'(v) + longint'(s) : longint'(v) - longint'(s);
         if (sum > 64'sd2147483647) return 32'sh7FFF_FFFF;
         if (sum < -64'sd2147483648) return 32'sh8000_0000;
         return sum[ctd_pkg::VAL_W-1:0];
      endfunction

      function void queue_all_params();
         ctd_pkg::ctd_rsp_type e;
         for (int i = 0; i < ctd_pkg::N_TUNED; i++) begin
            e.out_index  = ctd_pkg::IDX_W'(i);
            e.out_value  = trial[i];
            e.best_score = best_score;
            e.last       = (i == ctd_pkg::N_TUNED - 1);
            pending_params.insert(pending_params.size(), e);
         end
      endfunction

      function void note_request(ctd_pkg::ctd_req_type r);
         logic signed [ctd_pkg::VAL_W-1:0] sc;
         logic [63:0]                      prod;
         int unsigned                      a;
         beats_seen++;
         if (r.req_type == ctd_pkg::REQ_LOAD) begin
            if (r.entry_index < ctd_pkg::N_TUNED) begin
               trial[r.entry_index]     = r.start_value;
               best_val[r.entry_index]  = r.start_value;
               base_val[r.entry_index]  = r.start_value;
               step[r.entry_index]      = r.base_step;
               init_step[r.entry_index] = r.base_step;
            end
            return;
         end
         scores_seen++;
         sc = r.score;
         if (!have_best) begin
            have_best  = 1'b1;
            best_score = sc;
            queue_all_params();
            return;
         end
         a = (active < ctd_pkg::N_TUNED) ? active : 0;
         if (sc > best_score) begin
            // improvement: keep the trial, walk on in the same direction
            best_score  = sc;
            best_val[a] = trial[a];
            base_val[a] = trial[a];
            trial[a]    = nudge(trial[a], step[a], going_up);
         end else begin
            // failure: back to base, shrink the step, maybe flip or advance
            trial[a] = base_val[a];
            prod     = {32'd0, step[a]} * {48'd0, decay};
            step[a]  = prod[47:16];
            if (step[a] < min_step) begin
               step[a] = init_step[a];
               if (going_up) begin
                  going_up = 1'b0;
               end else begin
                  trial[a] = best_val[a];
                  going_up = 1'b1;
                  active   = (a + 1) % ctd_pkg::N_TUNED;
                  queue_all_params();
                  return;
               end
            end
            trial[a] = nudge(trial[a], step[a], going_up);
            if (trial[a] < 0) trial[a] = '0;
         end
         queue_all_params();
      endfunction

      function void check_response(ctd_pkg::ctd_rsp_type got);
         ctd_pkg::ctd_rsp_type want;
         if (pending_params.size() == 0) begin
            $error("unexpected result beat: out_index %0d out_value %0d",
                   got.out_index, got.out_value);
            errors++;
            return;
         end
         want = pending_params.pop_front();
         results_seen++;
         if (got.out_index !== want.out_index) begin
            $error("out_index: expected %0d, actual %0d", want.out_index, got.out_index);
            errors++;
         end
         if (got.out_value !== want.out_value) begin
            $error("out_value: expected %0d, actual %0d", want.out_value, got.out_value);
            errors++;
         end
         if (got.best_score !== want.best_score) begin
            $error("best_score: expected %0d, actual %0d", want.best_score, got.best_score);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   ctd_pkg::ctd_req_type          req_payload = '0;
   logic                          rsp_strobe;
   ctd_pkg::ctd_rsp_type          rsp_payload;
   logic                          csr_we = 1'b0;
   logic [ctd_pkg::CSR_IDX_W-1:0] csr_index = ctd_pkg::CSR_DECAY;
   logic [ctd_pkg::CSR_W-1:0]     csr_wdata = '0;

   tuner_scoreboard sb = new();
   int              idle_pct = 0;
   int              burst_left = 0;
   int              cycle_count = 0;

   coordinate_descent_tuner_top uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // result beats cannot be held off: check each strobe as it goes by
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_payload);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic ctd_pkg::ctd_req_type load_beat(int idx,
         logic signed [ctd_pkg::VAL_W-1:0] v, logic [ctd_pkg::VAL_W-1:0] s);
      ctd_pkg::ctd_req_type r;
      r.req_type    = ctd_pkg::REQ_LOAD;
      r.entry_index = ctd_pkg::IDX_W'(idx);
      r.start_value = v;
      r.base_step   = s;
      r.score       = $urandom();
      return r;
   endfunction

   function automatic ctd_pkg::ctd_req_type score_beat(logic signed [ctd_pkg::VAL_W-1:0] sc);
      ctd_pkg::ctd_req_type r;
      r.req_type    = ctd_pkg::REQ_SCORE;
      r.entry_index = ctd_pkg::IDX_W'($urandom());
      r.start_value = $urandom();
      r.base_step   = $urandom();
      r.score       = sc;
      return r;
   endfunction

   // scores mostly just above or below the current best so the search moves
   function automatic ctd_pkg::ctd_req_type random_beat();
      int                               k;
      logic signed [ctd_pkg::VAL_W-1:0] v;
      logic [ctd_pkg::VAL_W-1:0]        s;
      k = $urandom_range(0, 99);
      if (k < 12) begin
         v = ($urandom_range(0, 2) != 0) ?
             $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000 : $urandom();
         k = $urandom_range(0, 9);
         if (k < 6)      s = $urandom_range(32'h100, 32'h4_0000);
         else if (k < 8) s = $urandom();
         else if (k < 9) s = '0;
         else            s = $urandom_range(1, 255);
         return load_beat($urandom_range(0, 7), v, s);
      end
      k = $urandom_range(0, 99);
      if (k < 45)
         v = tuner_scoreboard::nudge(sb.best_score, $urandom_range(1, 32'h3_0000), 1'b1);
      else if (k < 75)
         v = tuner_scoreboard::nudge(sb.best_score, $urandom_range(1, 32'h3_0000), 1'b0);
      else if (k < 87)
         v = sb.best_score;
      else
         v = $urandom();
      return score_beat(v);
   endfunction

   // one input beat; start is left high so back-to-back beats need no toggle
   task automatic send(ctd_pkg::ctd_req_type r);
      int gap;
      gap = 0;
      if (burst_left > 0)
         burst_left--;
      else if ($urandom_range(0, 19) == 0)
         burst_left = $urandom_range(5, 12);
      else if ($urandom_range(0, 99) < idle_pct)
         gap = $urandom_range(1, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   // hold the sender until every expected beat is out and the block is quiet
   task automatic drain();
      start <= 1'b0;
      while (sb.pending_params.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(logic [ctd_pkg::DECAY_W-1:0] decay,
                             logic [ctd_pkg::CSR_W-1:0] min_step);
      csr_we    <= 1'b1;
      csr_index <= ctd_pkg::CSR_DECAY;
      csr_wdata <= ctd_pkg::CSR_W'(decay);
      @(posedge clock);
      sb.write_reg(ctd_pkg::CSR_DECAY, ctd_pkg::CSR_W'(decay));
      csr_index <= ctd_pkg::CSR_MIN_STEP;
      csr_wdata <= min_step;
      @(posedge clock);
      sb.write_reg(ctd_pkg::CSR_MIN_STEP, min_step);
      csr_we <= 1'b0;
   endtask

   initial begin
      int useful;
      ctd_pkg::ctd_req_type r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme loads, ignored indexes, first and equal scores
      send(load_beat(0, 32'sh0000_0000, 32'h0001_0000));
      send(load_beat(1, 32'sh7FFF_0000, 32'hFFFF_FFFF));
      send(load_beat(2, 32'sh8000_0000, 32'h0001_0000));
      send(load_beat(3, 32'sh1234_5678, 32'h0000_0005));
      send(load_beat(7, 32'shFFFF_FFFF, 32'hFFFF_FFFF));
      send(score_beat(32'sh8000_0000));
      send(score_beat(32'sh8000_0000));
      send(score_beat(32'sh8000_0001));
      send(score_beat(32'sh7FFF_FFFF));
      send(score_beat(32'sh7FFF_FFFF));
      drain();

      // every failure now resets the step: flip, advance, wrap, clamp at zero
      write_regs(ctd_pkg::DECAY_RESET, 32'hFFFF_FFFF);
      repeat (3) begin
         send(score_beat(32'sh7FFF_FFFF));
         send(score_beat(32'sh0000_0000));
      end
      drain();

      // random phases, one register setting each
      for (int p = 0; p < PHASES; p++) begin
         write_regs(PHASE_DECAY[p], PHASE_MIN_STEP[p]);
         idle_pct   = PHASE_IDLE[p];
         burst_left = 0;
         useful     = 0;
         while (useful < PHASE_BEATS) begin
            r = random_beat();
            if (r.req_type == ctd_pkg::REQ_SCORE || r.entry_index < ctd_pkg::N_TUNED) useful++;
            send(r);
         end
         drain();
      end

      if (sb.pending_params.size() != 0) begin
         $error("%0d expected result beats never arrived", sb.pending_params.size());
         sb.errors++;
      end
      $display("summary: %0d input beats (%0d scores), %0d result beats checked",
               sb.beats_seen, sb.scores_seen, sb.results_seen);
      $display("summary: %0d register settings, sender idle at 0/14/77 percent", PHASES + 1);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/core/ctd_pkg.sv
rtl/core/ctd_param_ram.sv
rtl/core/ctd_step_unit.sv
rtl/core/coordinate_descent_tuner_top.sv
tb/tb_coordinate_descent_tuner_top.sv
